// ----- sv/fcd_pkg.sv -----
package fcd_pkg;

    // Sample and gain format
    localparam int SAMPLE_W       = 16;
    localparam int GAIN_W         = 16;
    localparam int GAIN_FRAC_BITS = 14;
    localparam int PROD_W         = SAMPLE_W + GAIN_W;
    localparam int ACC_W          = PROD_W + 1;

    // Delay line geometry
    localparam int MAX_DELAY = 4096;
    localparam int ADDR_W    = $clog2(MAX_DELAY);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int LEN_W     = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd3;

    localparam logic [LEN_W-1:0]         RST_DELAY_LENGTH  = 13'd3528;
    localparam logic signed [GAIN_W-1:0] RST_DRY_GAIN      = 16'sd9830;
    localparam logic signed [GAIN_W-1:0] RST_WET_GAIN      = 16'sd11469;
    localparam logic signed [GAIN_W-1:0] RST_FEEDBACK_GAIN = 16'sd13107;

    // Delay line slot picked for one sample
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              full;
    } fcd_slot_t;

    // Drop the gain fraction, truncating toward zero, then clamp to a sample
    function automatic logic signed [SAMPLE_W-1:0] scale_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]           biased;
        logic [ACC_W-GAIN_FRAC_BITS-1:0]   q;
        logic signed [SAMPLE_W-1:0]        res;
        biased = v + (v[ACC_W-1] ? {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}}
                                 : {ACC_W{1'b0}});
        q = biased[ACC_W-1:GAIN_FRAC_BITS];
        if ((q[ACC_W-GAIN_FRAC_BITS-1:SAMPLE_W-1] == '0) ||
            (q[ACC_W-GAIN_FRAC_BITS-1:SAMPLE_W-1] == '1))
        begin
            res = q[SAMPLE_W-1:0];
        end
        else if (q[ACC_W-GAIN_FRAC_BITS-1])
        begin
            res = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ----- sv/fcd_if.sv -----
interface fcd_in_if;
    import fcd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fcd_out_if;
    import fcd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- sv/fcd_addr_gen.sv -----
module fcd_addr_gen (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [fcd_pkg::LEN_W-1:0] delay_length,
    input  logic                      accept,
    output fcd_pkg::fcd_slot_t        slot
);
    import fcd_pkg::*;

    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;

    logic [CNT_W-1:0]  len;
    logic [ADDR_W-1:0] ptr_cur;
    logic [CNT_W-1:0]  fill_cur;
    logic [CNT_W-1:0]  ptr_inc;
    logic              full;

    // Clamp the length and bring pointer and fill count inside it
    always_comb
    begin
        if (delay_length == '0)
        begin
            len = CNT_W'(1);
        end
        else if (32'(delay_length) > 32'(MAX_DELAY))
        begin
            len = CNT_W'(MAX_DELAY);
        end
        else
        begin
            len = CNT_W'(delay_length);
        end

        ptr_cur  = ({1'b0, ptr_reg} >= len) ? '0 : ptr_reg;
        fill_cur = (fill_reg > len) ? len : fill_reg;
        full     = (fill_cur == len);

        // Advance the circular pointer and count up while filling
        ptr_inc   = {1'b0, ptr_cur} + CNT_W'(1);
        ptr_next  = (ptr_inc >= len) ? '0 : ptr_inc[ADDR_W-1:0];
        fill_next = full ? fill_cur : fill_cur + CNT_W'(1);
    end

    assign slot.addr = ptr_cur;
    assign slot.full = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- sv/feedback_comb_delay.sv -----
// Channel  | Dir | Payload          | Transfer
// ---------+-----+------------------+--------------------------
// in_ch    | in  | sample_in  [15:0] | valid && ready at clk rise
// out_ch   | out | sample_out [15:0] | valid && ready at clk rise
// cfg      | in  | cfg_index, cfg_data | cfg_we at clk rise
//
// One sample per cycle unless an output stall or a delay entry hazard holds the input;
// each sample takes delay memory read, multiply, sum and saturate into the output register.
// With a delay length of one, each sample reads what the previous one writes,
// so input ready drops after each accepted sample until that sample leaves stage 1.
// Reset clears pointer, fill count and valids and loads config defaults; memory is not cleared.
// An output stall freezes the whole pipeline; the input is still taken while the
// output register drains in the same cycle.
module feedback_comb_delay (
    input  logic                           clk,
    input  logic                           rst_n,
    fcd_in_if.sink                         in_ch,
    fcd_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [fcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fcd_pkg::*;

    // Configuration registers
    logic [LEN_W-1:0]         delay_length_reg;
    logic signed [GAIN_W-1:0] dry_gain_reg;
    logic signed [GAIN_W-1:0] wet_gain_reg;
    logic signed [GAIN_W-1:0] feedback_gain_reg;

    // Delay memory and last write for forwarding
    logic signed [SAMPLE_W-1:0] mem [MAX_DELAY];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       lw_valid_reg;
    logic [ADDR_W-1:0]          lw_addr_reg;
    logic signed [SAMPLE_W-1:0] lw_data_reg;

    // Stage 1: read data arrives
    logic                       s1_valid_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic                       s1_full_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    logic signed [SAMPLE_W-1:0] s1_d;

    // Stage 2: products
    logic                       s2_valid_reg;
    logic [ADDR_W-1:0]          s2_addr_reg;
    logic signed [SAMPLE_W-1:0] s2_d_reg;
    logic signed [PROD_W-1:0]   s2_p_dry_reg;
    logic signed [PROD_W-1:0]   s2_p_wet_reg;
    logic signed [PROD_W-1:0]   s2_p_fb_reg;
    logic signed [ACC_W-1:0]    s2_y_acc;
    logic signed [ACC_W-1:0]    s2_w_acc;
    logic signed [SAMPLE_W-1:0] s2_y;
    logic signed [SAMPLE_W-1:0] s2_w;

    // Output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;

    logic      move;
    logic      hazard;
    logic      accept;
    logic      wr_en;
    fcd_slot_t slot;

    // Pipeline control
    assign move        = !out_valid_reg || out_ch.ready;
    assign hazard      = s1_valid_reg && (s1_addr_reg == slot.addr);
    assign in_ch.ready = move && !hazard;
    assign accept      = in_ch.valid && in_ch.ready;
    assign wr_en       = move && s2_valid_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg  <= RST_DELAY_LENGTH;
            dry_gain_reg      <= RST_DRY_GAIN;
            wet_gain_reg      <= RST_WET_GAIN;
            feedback_gain_reg <= RST_FEEDBACK_GAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELAY_LENGTH:  delay_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_DRY_GAIN:      dry_gain_reg      <= cfg_data;
                CFG_WET_GAIN:      wet_gain_reg      <= cfg_data;
                CFG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    fcd_addr_gen u_addr_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .delay_length (delay_length_reg),
        .accept       (accept),
        .slot         (slot)
    );

    // Read the oldest entry on transfer, write back the new one from stage 2
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s2_addr_reg] <= s2_w;
        end
        if (accept)
        begin
            rd_data_reg <= mem[slot.addr];
        end
    end

    // Hold the last write for a read issued on the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lw_addr_reg <= s2_addr_reg;
            lw_data_reg <= s2_w;
        end
    end

    // Valids of all pipeline stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= slot.addr;
            s1_full_reg <= slot.full;
            s1_x_reg    <= in_ch.sample_in;
        end
    end

    // Pick forwarded or memory data; a line still filling contributes nothing
    always_comb
    begin
        if (!s1_full_reg)
        begin
            s1_d = '0;
        end
        else if (lw_valid_reg && (lw_addr_reg == s1_addr_reg))
        begin
            s1_d = lw_data_reg;
        end
        else
        begin
            s1_d = rd_data_reg;
        end
    end

    // Multiply into stage 2
    always_ff @(posedge clk)
    begin
        if (move && s1_valid_reg)
        begin
            s2_addr_reg  <= s1_addr_reg;
            s2_d_reg     <= s1_d;
            s2_p_dry_reg <= s1_x_reg * dry_gain_reg;
            s2_p_wet_reg <= s1_x_reg * wet_gain_reg;
            s2_p_fb_reg  <= s1_d * feedback_gain_reg;
        end
    end

    // Sum at full precision, scale and saturate
    always_comb
    begin
        s2_y_acc = {s2_p_dry_reg[PROD_W-1], s2_p_dry_reg}
                 + {{(ACC_W-SAMPLE_W-GAIN_FRAC_BITS){s2_d_reg[SAMPLE_W-1]}},
                    s2_d_reg, {GAIN_FRAC_BITS{1'b0}}};
        s2_w_acc = {s2_p_wet_reg[PROD_W-1], s2_p_wet_reg}
                 + {s2_p_fb_reg[PROD_W-1], s2_p_fb_reg};
        s2_y     = scale_sat(s2_y_acc);
        s2_w     = scale_sat(s2_w_acc);
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (move && s2_valid_reg)
        begin
            out_sample_reg <= s2_y;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;

    // Items in flight never share a delay line entry
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg) |-> (s1_addr_reg != s2_addr_reg))
        else $error("two samples in flight on the same delay entry");

    // A transfer always lands in stage 1
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted sample lost before stage 1");

    // A write back always comes from an item that then shows at the output
    a_write_out: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> out_valid_reg)
        else $error("delay write without an output sample");

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    import fcd_pkg::*;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;

    localparam int      IDLE_PCT       = 27;
    localparam int      LATENCY        = 3;
    localparam int      HOLD_CYCLES    = 300;
    localparam int      STALL_LIMIT    = 4000;
    localparam int      MAX_REPORTS    = 10;
    localparam int      PREFILL_LEN    = 512;
    localparam int      LONG_ITEMS     = 100;
    localparam int      RANDOM_ITEMS   = 1150;
    localparam sample_t SAMPLE_MAX     = 16'sh7fff;
    localparam sample_t SAMPLE_MIN     = 16'sh8000;
    localparam gain_t   GAIN_UNITY     = 16'sd16384;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fcd_in_if  in_ch();
    fcd_out_if out_ch();

    feedback_comb_delay u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted register and delay line contents
    logic [LEN_W-1:0] cfg_len;
    gain_t            cfg_dry;
    gain_t            cfg_wet;
    gain_t            cfg_fb;
    sample_t          line_mem [MAX_DELAY];
    int unsigned      line_ptr;
    int unsigned      line_fill;

    sample_t expected_samples [$];
    int      faults        = 0;
    int      hold_requests = 0;
    bit      steady        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Drop the gain fraction toward zero and clamp to the sample range
    function automatic sample_t to_sample(input longint acc);
        longint q;
        q = acc / (longint'(1) << GAIN_FRAC_BITS);
        if (q > longint'(SAMPLE_MAX))
            q = longint'(SAMPLE_MAX);
        if (q < longint'(SAMPLE_MIN))
            q = longint'(SAMPLE_MIN);
        return q[SAMPLE_W-1:0];
    endfunction

    // Effective line length: zero acts as one, oversized clamps to the memory
    function automatic int unsigned line_len(input int unsigned len);
        if (len == 0)
            return 1;
        if (len > MAX_DELAY)
            return MAX_DELAY;
        return len;
    endfunction

    // Advance the comb filter by one sample and return the output sample
    function automatic sample_t comb_predict(input sample_t x);
        int unsigned n;
        longint      held;
        longint      out_acc;
        longint      line_acc;
        n = line_len(32'(cfg_len));
        if (line_ptr >= n)
            line_ptr = 0;
        if (line_fill > n)
            line_fill = n;
        out_acc  = longint'(x) * longint'(cfg_dry);
        line_acc = longint'(x) * longint'(cfg_wet);
        // full line: pass the oldest entry at unity and feed it back
        if (line_fill == n)
        begin
            held     = longint'(line_mem[line_ptr[ADDR_W-1:0]]);
            out_acc  += held * (longint'(1) << GAIN_FRAC_BITS);
            line_acc += held * longint'(cfg_fb);
        end
        else
        begin
            line_fill++;
        end
        line_mem[line_ptr[ADDR_W-1:0]] = to_sample(line_acc);
        line_ptr++;
        if (line_ptr >= n)
            line_ptr = 0;
        return to_sample(out_acc);
    endfunction

    function automatic sample_t rand_sample();
        int v;
        case ($urandom_range(7))
            0:       v = $urandom_range(1) ? int'(SAMPLE_MAX) : int'(SAMPLE_MIN);
            1:       v = $urandom_range(64) - 32;
            default: v = $urandom;
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic gain_t rand_gain();
        int v;
        case ($urandom_range(5))
            0:
            begin
                case ($urandom_range(4))
                    0:       v = int'(SAMPLE_MIN);
                    1:       v = int'(SAMPLE_MAX);
                    2:       v = 0;
                    3:       v = 16384;
                    default: v = -16384;
                endcase
            end
            1, 2:    v = $urandom_range(8192) - 4096;
            default: v = $urandom;
        endcase
        return v[GAIN_W-1:0];
    endfunction

    // Offer one sample, with random idle gaps, and hold it until the transfer
    task automatic send_sample(input sample_t x);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= x;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_samples.push_back(comb_predict(x));
    endtask

    // Drop valid and wait until every predicted sample has come out
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_DELAY_LENGTH:  cfg_len = data[LEN_W-1:0];
            CFG_DRY_GAIN:      cfg_dry = data;
            CFG_WET_GAIN:      cfg_wet = data;
            CFG_FEEDBACK_GAIN: cfg_fb  = data;
            default:           ;
        endcase
    endtask

    task automatic configure(input logic [LEN_W-1:0] len, input gain_t dry, input gain_t wet,
                             input gain_t fb);
        write_reg(CFG_DELAY_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_DRY_GAIN, dry);
        write_reg(CFG_WET_GAIN, wet);
        write_reg(CFG_FEEDBACK_GAIN, fb);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Reset gains and length, line still filling: only the dry path shows
    task automatic test_reset_defaults();
        sample_t probe [10];
        probe = '{SAMPLE_MAX, SAMPLE_MIN, 16'sd0, -16'sd1, 16'sd1,
                  16'sh5555, 16'shaaaa, 16'sd16384, -16'sd16384, 16'sd100};
        foreach (probe[i])
            send_sample(probe[i]);
        drain();
    endtask

    // Fill a mid-size line, wrap it, and stall the output while the input keeps coming
    task automatic test_prefill();
        configure(LEN_W'(PREFILL_LEN), GAIN_UNITY, 16'sd12000, -16'sd8192);
        for (int i = 0; i < PREFILL_LEN + 64; i++)
        begin
            if (i == 100)
                hold_requests++;
            send_sample(rand_sample());
        end
        drain();
    endtask

    // Zero, one and two sample delays, extreme gains, truncation of small negatives
    task automatic test_short_lines();
        configure(13'd0, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd0);
        drain();
        configure(13'd1, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(SAMPLE_MAX);
        drain();
        configure(13'd2, 16'sd1, -16'sd1, GAIN_UNITY);
        send_sample(-16'sd1);
        send_sample(-16'sd16385);
        send_sample(16'sd16383);
        send_sample(16'sd0);
        drain();
    endtask

    // Oversized length clamps to the memory depth; the line only fills here
    task automatic test_oversized_length();
        configure(13'd8191, 16'sd8192, -16'sd12000, 16'sd4096);
        repeat (LONG_ITEMS) send_sample(rand_sample());
        drain();
    endtask

    // Random settings per phase, mostly short lines, one phase with no idling
    task automatic test_random_mix();
        int unsigned len_pick;
        int unsigned n_pick;
        int unsigned fill_now;
        int          phase_items;
        int          total;
        int          phase;
        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS)
        begin
            steady      = (phase == 2);
            phase_items = steady ? 300 : int'($urandom_range(40, 200));
            case ($urandom_range(19))
                0, 1:                   len_pick = $urandom_range(1);
                2, 3, 4, 5, 6, 7, 8, 9,
                10, 11, 12:             len_pick = $urandom_range(2, 32);
                13, 14, 15, 16, 17:     len_pick = $urandom_range(33, 400);
                18:                     len_pick = $urandom_range(401, MAX_DELAY);
                default:                len_pick = $urandom_range(MAX_DELAY, 8191);
            endcase
            // Keep lines longer than the prefill short of full, so no read
            // reaches an entry that was never written
            n_pick   = line_len(len_pick);
            fill_now = (line_fill > n_pick) ? n_pick : line_fill;
            if (n_pick > PREFILL_LEN && fill_now + phase_items >= n_pick)
                len_pick = $urandom_range(2, PREFILL_LEN);
            configure(len_pick[LEN_W-1:0], rand_gain(), rand_gain(), rand_gain());
            repeat (phase_items) send_sample(rand_sample());
            drain();
            steady = 1'b0;
            total += phase_items;
            phase++;
        end
    endtask

    // Drive the output ready: random stalls, requested hold-offs, steady stretches
    initial
    begin : result_sink
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (steady)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each output transfer with the oldest predicted sample
    always @(posedge clk)
    begin : check_samples
        sample_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("ERROR: sample_out %0d with nothing pending", out_ch.sample_out);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (out_ch.sample_out !== want)
                begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("ERROR: sample_out expected %0d, got %0d",
                                 want, out_ch.sample_out);
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : run
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_DELAY_LENGTH;
        cfg_data        = '0;
        cfg_len         = RST_DELAY_LENGTH;
        cfg_dry         = RST_DRY_GAIN;
        cfg_wet         = RST_WET_GAIN;
        cfg_fb          = RST_FEEDBACK_GAIN;
        line_ptr        = 0;
        line_fill       = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // The prefill pass writes every entry that a line of up to PREFILL_LEN can read
        test_reset_defaults();
        test_prefill();
        test_short_lines();
        test_oversized_length();
        test_random_mix();
        drain();

        if (faults == 0 && expected_samples.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
